// ----- hdl/pcbs_pkg.sv -----
// Package for the per-class box suppression block.
// Box record types, register indexes and controller states; no dependencies.
package pcbs_pkg;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } geo_t;

  typedef struct packed {
    logic [15:0] score;
    logic [7:0]  cls;
  } sc_t;

  // Result of one overlap test, leaving the overlap pipeline
  typedef struct packed {
    logic valid;
    logic sup;
  } ovl_res_t;

  typedef enum logic [3:0] {
    S_LOAD, S_FIND, S_FIND_WAIT, S_FLUSH, S_GEO, S_GEO_WAIT,
    S_SUPP, S_SUPP_WAIT, S_LAST
  } state_t;

  typedef enum logic [1:0] {
    RD_FIND, RD_GEO, RD_SUPP
  } rd_kind_t;

  localparam logic REG_IOU_LIMIT   = 1'b0;
  localparam logic REG_CLASS_COUNT = 1'b1;

  localparam logic [10:0] IOU_LIMIT_RST   = 11'd410;
  localparam logic [8:0]  CLASS_COUNT_RST = 9'd80;
  localparam logic [17:0] PIX_ONE         = 18'sd16;

endpackage

// ----- hdl/per_class_box_suppression.sv -----
// Per-class greedy box suppression: top level with controller, registers, output.
// Instantiates pcbs_box_mem and pcbs_overlap; uses pcbs_pkg.
//
// Boxes are taken one per cycle into a box memory of MAX_BOXES entries; boxes
// beyond that are dropped and flag the run as overflowed. A request with
// is_final set closes the set and starts the run, during which in_stall stays
// high. The run repeats a find pass (n reads to pick the best candidate by
// class ascending, score descending, earlier box first), one read of the kept
// box, and a suppression pass (n reads through a four-stage overlap pipeline)
// for each kept box, plus a final find pass. The run time is bound by the single
// read port of the box memory, plus any output stall. Each result is released
// once the next find pass decides whether it is the last; an empty run yields
// one result with none_kept set and zero box fields. Class ids at or above
// class_count are skipped. Candidate flags live in flip-flops cleared at reset
// and at the end of each run, so no memory clearing pass is needed.
module per_class_box_suppression
  import pcbs_pkg::*;
#(
  parameter int MAX_BOXES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // input boxes
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_box_x,
  input  logic signed [15:0] in_box_y,
  input  logic [14:0]        in_box_width,
  input  logic [14:0]        in_box_height,
  input  logic [15:0]        in_score,
  input  logic [7:0]         in_class_id,
  input  logic               in_is_final,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic [14:0]        out_width,
  output logic [14:0]        out_height,
  output logic [15:0]        out_score,
  output logic [7:0]         out_class,
  output logic               out_last_of_run,
  output logic               out_none_kept,
  output logic               out_overflowed,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  // configuration registers
  logic [10:0] limit_r;
  logic [8:0]  ccount_r;

  // controller state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [MAX_BOXES-1:0] cand_r, cand_nxt;
  logic [IDX_W-1:0]   scan_r, scan_nxt;
  logic               rd_v_r, rd_v_nxt;
  rd_kind_t           rd_kind_r, rd_kind_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               best_v_r, best_v_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  sc_t                best_sc_r, best_sc_nxt;
  logic               held_v_r, held_v_nxt;
  geo_t               held_geo_r, held_geo_nxt;
  sc_t                held_sc_r, held_sc_nxt;

  // output register
  logic               out_v_r, out_v_nxt;
  geo_t               out_geo_r, out_geo_nxt;
  sc_t                out_sc_r, out_sc_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_none_r, out_none_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  // memory and overlap hookup
  logic               wr_en;
  geo_t               wr_geo;
  sc_t                wr_sc;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  geo_t               rd_geo;
  sc_t                rd_sc;
  logic               ovl_in_v;
  ovl_res_t           ovl_res;
  logic [IDX_W-1:0]   ovl_idx;
  logic               ovl_busy;

  logic in_acc, out_free, last_scan, find_hit, better;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_LOAD);
  assign out_free  = !out_v_r || !out_stall;
  assign last_scan = (CNT_W'(scan_r) == cnt_r - CNT_W'(1));

  assign wr_geo = '{x: in_box_x, y: in_box_y, w: in_box_width, h: in_box_height};
  assign wr_sc  = '{score: in_score, cls: in_class_id};
  assign wr_en  = in_acc && (cnt_r < CNT_W'(MAX_BOXES));

  pcbs_box_mem #(.DEPTH(MAX_BOXES), .AW(IDX_W)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_geo  (wr_geo),
    .wr_sc   (wr_sc),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_geo  (rd_geo),
    .rd_sc   (rd_sc)
  );

  // Only same-class live candidates enter the overlap pipeline
  assign ovl_in_v = rd_v_r && (rd_kind_r == RD_SUPP) && cand_r[rd_idx_r] &&
                    (rd_sc.cls == held_sc_r.cls);

  pcbs_overlap #(.AW(IDX_W)) u_ovl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (ovl_in_v),
    .in_idx  (rd_idx_r),
    .kept    (held_geo_r),
    .cand    (rd_geo),
    .limit   (limit_r),
    .res     (ovl_res),
    .res_idx (ovl_idx),
    .busy    (ovl_busy)
  );

  // Find pass: strict compare keeps the earlier box on equal keys
  assign find_hit = rd_v_r && (rd_kind_r == RD_FIND) && cand_r[rd_idx_r] &&
                    ({1'b0, rd_sc.cls} < ccount_r);
  assign better   = !best_v_r || (rd_sc.cls < best_sc_r.cls) ||
                    ((rd_sc.cls == best_sc_r.cls) && (rd_sc.score > best_sc_r.score));

  // Configuration port
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_IOU_LIMIT:   prdata = 32'(limit_r);
      REG_CLASS_COUNT: prdata = 32'(ccount_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= IOU_LIMIT_RST;
      ccount_r <= CLASS_COUNT_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_IOU_LIMIT) limit_r <= pwdata[10:0];
      else                           ccount_r <= pwdata[8:0];
    end
  end

  // Next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    cand_nxt     = cand_r;
    scan_nxt     = scan_r;
    rd_v_nxt     = 1'b0;
    rd_kind_nxt  = rd_kind_r;
    rd_idx_nxt   = rd_idx_r;
    best_v_nxt   = best_v_r;
    best_idx_nxt = best_idx_r;
    best_sc_nxt  = best_sc_r;
    held_v_nxt   = held_v_r;
    held_geo_nxt = held_geo_r;
    held_sc_nxt  = held_sc_r;
    out_v_nxt    = out_v_r && out_stall;
    out_geo_nxt  = out_geo_r;
    out_sc_nxt   = out_sc_r;
    out_last_nxt = out_last_r;
    out_none_nxt = out_none_r;
    out_ovf_nxt  = out_ovf_r;
    rd_en        = 1'b0;
    rd_addr      = scan_r;

    // Track the best candidate as read data returns
    if (find_hit && better) begin
      best_v_nxt   = 1'b1;
      best_idx_nxt = rd_idx_r;
      best_sc_nxt  = rd_sc;
    end
    // Drop boxes the kept box overlaps too much
    if (ovl_res.valid && ovl_res.sup) cand_nxt[ovl_idx] = 1'b0;
    // Kept box arrives from memory
    if (rd_v_r && (rd_kind_r == RD_GEO)) begin
      held_v_nxt   = 1'b1;
      held_geo_nxt = rd_geo;
      held_sc_nxt  = rd_sc;
    end

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (wr_en) begin
            cand_nxt[cnt_r[IDX_W-1:0]] = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_is_final) begin
            state_nxt  = S_FIND;
            scan_nxt   = '0;
            best_v_nxt = 1'b0;
          end
        end
      end
      S_FIND: begin
        rd_en       = 1'b1;
        rd_v_nxt    = 1'b1;
        rd_kind_nxt = RD_FIND;
        rd_idx_nxt  = scan_r;
        scan_nxt    = scan_r + IDX_W'(1);
        if (last_scan) state_nxt = S_FIND_WAIT;
      end
      S_FIND_WAIT: begin
        if (!rd_v_r) state_nxt = best_v_r ? S_FLUSH : S_LAST;
      end
      S_FLUSH: begin
        // Release the previous kept box; another one follows it
        if (!held_v_r) begin
          state_nxt = S_GEO;
        end else if (out_free) begin
          out_v_nxt    = 1'b1;
          out_geo_nxt  = held_geo_r;
          out_sc_nxt   = held_sc_r;
          out_last_nxt = 1'b0;
          out_none_nxt = 1'b0;
          out_ovf_nxt  = ovf_r;
          held_v_nxt   = 1'b0;
          state_nxt    = S_GEO;
        end
      end
      S_GEO: begin
        rd_en       = 1'b1;
        rd_addr     = best_idx_r;
        rd_v_nxt    = 1'b1;
        rd_kind_nxt = RD_GEO;
        rd_idx_nxt  = best_idx_r;
        cand_nxt[best_idx_r] = 1'b0;
        state_nxt   = S_GEO_WAIT;
      end
      S_GEO_WAIT: begin
        scan_nxt  = '0;
        state_nxt = S_SUPP;
      end
      S_SUPP: begin
        rd_en       = 1'b1;
        rd_v_nxt    = 1'b1;
        rd_kind_nxt = RD_SUPP;
        rd_idx_nxt  = scan_r;
        scan_nxt    = scan_r + IDX_W'(1);
        if (last_scan) state_nxt = S_SUPP_WAIT;
      end
      S_SUPP_WAIT: begin
        if (!rd_v_r && !ovl_busy) begin
          scan_nxt   = '0;
          best_v_nxt = 1'b0;
          state_nxt  = S_FIND;
        end
      end
      S_LAST: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_last_nxt = 1'b1;
          out_ovf_nxt  = ovf_r;
          out_none_nxt = !held_v_r;
          out_geo_nxt  = held_v_r ? held_geo_r : '0;
          out_sc_nxt   = held_v_r ? held_sc_r : '0;
          held_v_nxt   = 1'b0;
          cand_nxt     = '0;
          cnt_nxt      = '0;
          ovf_nxt      = 1'b0;
          state_nxt    = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      cand_r   <= '0;
      rd_v_r   <= 1'b0;
      best_v_r <= 1'b0;
      held_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      cand_r   <= cand_nxt;
      rd_v_r   <= rd_v_nxt;
      best_v_r <= best_v_nxt;
      held_v_r <= held_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    rd_kind_r  <= rd_kind_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_sc_r  <= best_sc_nxt;
    held_geo_r <= held_geo_nxt;
    held_sc_r  <= held_sc_nxt;
    out_geo_r  <= out_geo_nxt;
    out_sc_r   <= out_sc_nxt;
    out_last_r <= out_last_nxt;
    out_none_r <= out_none_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid       = out_v_r;
  assign out_x           = out_geo_r.x;
  assign out_y           = out_geo_r.y;
  assign out_width       = out_geo_r.w;
  assign out_height      = out_geo_r.h;
  assign out_score       = out_sc_r.score;
  assign out_class       = out_sc_r.cls;
  assign out_last_of_run = out_last_r;
  assign out_none_kept   = out_none_r;
  assign out_overflowed  = out_ovf_r;

  // An empty-run result is always the last one of its run
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_none_r |-> out_last_r)
    else $error("none_kept result not marked last");

  // The store never holds more boxes than it has entries
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BOXES))
    else $error("box count beyond store depth");

  // No memory read or overlap work is in flight while loading
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |-> !ovl_busy && !rd_v_r)
    else $error("run activity during load");

  // A run ends with no candidates left
  a_run_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LAST && out_free |=> cand_r == '0)
    else $error("candidates left after run");

endmodule

// ----- hdl/pcbs_box_mem.sv -----
// Box store: geometry and score/class memories, one write and one read port.
// Read data is registered. Uses pcbs_pkg.
module pcbs_box_mem
  import pcbs_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  geo_t          wr_geo,
  input  sc_t           wr_sc,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output geo_t          rd_geo,
  output sc_t           rd_sc
);

  geo_t geo_mem [DEPTH];
  sc_t  sc_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      geo_mem[wr_addr] <= wr_geo;
      sc_mem[wr_addr]  <= wr_sc;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_geo <= geo_mem[rd_addr];
      rd_sc  <= sc_mem[rd_addr];
    end
  end

endmodule

// ----- hdl/pcbs_overlap.sv -----
// Four-stage overlap test of one stored box against the kept box.
// Sides, products, union, threshold compare. Uses pcbs_pkg.
module pcbs_overlap
  import pcbs_pkg::*;
#(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_v,
  input  logic [AW-1:0] in_idx,
  input  geo_t          kept,
  input  geo_t          cand,
  input  logic [10:0]   limit,
  output ovl_res_t      res,
  output logic [AW-1:0] res_idx,
  output logic          busy
);

  logic signed [17:0] ka0, ka1, kb0, kb1, ca0, ca1, cb0, cb1;
  logic signed [17:0] lox, hix, loy, hiy, sx, sy;

  logic          s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic [AW-1:0] s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r;
  logic [15:0]   iw_r, ih_r;
  logic [14:0]   cw_r, ch_r;
  logic [31:0]   inter2_r, inter3_r;
  logic [29:0]   aa_r, ab_r;
  logic signed [32:0] uni_r;
  logic [40:0]   lhs_r;
  logic [41:0]   prod_r;
  logic          pos_r, zero_r;

  always_comb begin
    ka0 = 18'(kept.x);
    ka1 = 18'(kept.x) + 18'(signed'({1'b0, kept.w}));
    kb0 = 18'(kept.y);
    kb1 = 18'(kept.y) + 18'(signed'({1'b0, kept.h}));
    ca0 = 18'(cand.x);
    ca1 = 18'(cand.x) + 18'(signed'({1'b0, cand.w}));
    cb0 = 18'(cand.y);
    cb1 = 18'(cand.y) + 18'(signed'({1'b0, cand.h}));
    lox = (ka0 > ca0) ? ka0 : ca0;
    hix = (ka1 < ca1) ? ka1 : ca1;
    loy = (kb0 > cb0) ? kb0 : cb0;
    hiy = (kb1 < cb1) ? kb1 : cb1;
    sx  = hix - lox + signed'(PIX_ONE);
    sy  = hiy - loy + signed'(PIX_ONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= in_idx;
    iw_r     <= sx[17] ? 16'd0 : sx[15:0];
    ih_r     <= sy[17] ? 16'd0 : sy[15:0];
    cw_r     <= cand.w;
    ch_r     <= cand.h;
    s2_idx_r <= s1_idx_r;
    inter2_r <= 32'(iw_r) * 32'(ih_r);
    aa_r     <= 30'(kept.w) * 30'(kept.h);
    ab_r     <= 30'(cw_r) * 30'(ch_r);
    s3_idx_r <= s2_idx_r;
    inter3_r <= inter2_r;
    uni_r    <= signed'(33'(aa_r)) + signed'(33'(ab_r)) - signed'(33'(inter2_r));
    s4_idx_r <= s3_idx_r;
    lhs_r    <= {inter3_r[30:0], 10'd0};
    prod_r   <= 42'(limit) * 42'(uni_r[30:0]);
    pos_r    <= (uni_r > 33'sd0);
    zero_r   <= (uni_r == 33'sd0);
  end

  assign res.valid = s4_v_r;
  assign res.sup   = pos_r ? (42'(lhs_r) > prod_r) : zero_r;
  assign res_idx   = s4_idx_r;
  assign busy      = s1_v_r | s2_v_r | s3_v_r | s4_v_r;

endmodule
